// ===== sv/hexp_pkg.sv =====
// Shared types and constants for the hex text to bytes parser.
// No dependencies; imported by every module of the block.
package hexp_pkg;

    // Default width of the running byte counter
    localparam int COUNT_WIDTH_DEF = 16;

    // Widths fixed by the field layout
    localparam int CHAR_W   = 8;
    localparam int BYTE_W   = 8;
    localparam int CAP_W    = 16;
    localparam int OCOUNT_W = 16;
    localparam int STATUS_W = 3;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;

    // Character codes of interest
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [3:0]        NIB_TEN  = 4'd10;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_CHAR = 3'd1,
        ST_BAD_X    = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_ODD      = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    // Character classes
    typedef enum logic [2:0] {
        CK_TERM,
        CK_SKIP,
        CK_X,
        CK_DIGIT,
        CK_BAD
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] nibble;
    } t_char_class;

endpackage

// ===== sv/hexp_classify.sv =====
// Character classifier: sorts one text character into terminator, separator,
// x prefix, hex digit (with its value) or illegal. Depends on hexp_pkg.
module hexp_classify
    import hexp_pkg::*;
(
    input  logic [CHAR_W-1:0] i_char,
    output t_char_class       o_class
);

    logic [CHAR_W-1:0] w_off;

    // Decode class and nibble value
    always_comb begin
        w_off          = '0;
        o_class.kind   = CK_BAD;
        o_class.nibble = '0;
        if (i_char == CH_NUL) begin
            o_class.kind = CK_TERM;
        end else if ((i_char >= CH_TAB && i_char <= CH_CR) || i_char == CH_SPACE ||
                     i_char == CH_COLON || i_char == CH_DASH || i_char == CH_COMMA) begin
            o_class.kind = CK_SKIP;
        end else if (i_char == CH_LX || i_char == CH_UX) begin
            o_class.kind = CK_X;
        end else if (i_char >= CH_0 && i_char <= CH_9) begin
            w_off          = i_char - CH_0;
            o_class.kind   = CK_DIGIT;
            o_class.nibble = w_off[3:0];
        end else if (i_char >= CH_LA && i_char <= CH_LF) begin
            w_off          = i_char - CH_LA;
            o_class.kind   = CK_DIGIT;
            o_class.nibble = w_off[3:0] + NIB_TEN;
        end else if (i_char >= CH_UA && i_char <= CH_UF) begin
            w_off          = i_char - CH_UA;
            o_class.kind   = CK_DIGIT;
            o_class.nibble = w_off[3:0] + NIB_TEN;
        end
    end

endmodule

// ===== sv/hexp_core.sv =====
// Decoder core: string state (pending nibble, count, abort flag) and the
// result register with its output handshake. Depends on hexp_pkg.
module hexp_core
    import hexp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_char_class         i_class,
    input  logic [CAP_W-1:0]    i_capacity,
    output logic                o_slot_free,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [BYTE_W-1:0]   o_data_byte,
    output logic                o_byte_valid,
    output logic                o_final,
    output logic [STATUS_W-1:0] o_status,
    output logic [OCOUNT_W-1:0] o_byte_count
);

    localparam int CMP_W = (COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W;

    // String state
    logic                   r_pending, n_pending;
    logic [3:0]             r_high, n_high;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_aborted, n_aborted;

    // Result register
    logic                   r_out_valid;
    logic [BYTE_W-1:0]      r_out_byte;
    logic                   r_out_bvalid;
    logic                   r_out_final;
    t_status                r_out_status;
    logic [COUNT_WIDTH-1:0] r_out_count;

    // Result of the current beat
    logic                   w_proc;
    logic                   w_has_res;
    logic [BYTE_W-1:0]      w_byte;
    logic                   w_bvalid;
    logic                   w_final;
    t_status                w_status;
    logic                   w_full;

    assign o_slot_free = !r_out_valid || i_m_tready;
    assign w_proc      = i_valid && o_slot_free;
    assign w_full      = (CMP_W'(r_count) >= CMP_W'(i_capacity)) || (&r_count);

    // Next string state and result
    always_comb begin
        n_pending = r_pending;
        n_high    = r_high;
        n_count   = r_count;
        n_aborted = r_aborted;
        w_has_res = 1'b0;
        w_byte    = '0;
        w_bvalid  = 1'b0;
        w_final   = 1'b0;
        w_status  = ST_OK;
        if (r_aborted) begin
            // skip to terminator after an error
            if (i_class.kind == CK_TERM) begin
                n_pending = 1'b0;
                n_high    = '0;
                n_count   = '0;
                n_aborted = 1'b0;
            end
        end else begin
            unique case (i_class.kind)
                CK_TERM: begin
                    w_has_res = 1'b1;
                    w_final   = 1'b1;
                    if (r_pending) begin
                        w_status = ST_ODD;
                    end else if (r_count == '0) begin
                        w_status = ST_EMPTY;
                    end
                    n_pending = 1'b0;
                    n_high    = '0;
                    n_count   = '0;
                end
                CK_SKIP: begin
                end
                CK_X: begin
                    if (r_pending && r_high == '0) begin
                        n_pending = 1'b0;
                    end else begin
                        w_has_res = 1'b1;
                        w_final   = 1'b1;
                        w_status  = ST_BAD_X;
                        n_aborted = 1'b1;
                    end
                end
                CK_DIGIT: begin
                    if (!r_pending) begin
                        n_pending = 1'b1;
                        n_high    = i_class.nibble;
                    end else if (w_full) begin
                        w_has_res = 1'b1;
                        w_final   = 1'b1;
                        w_status  = ST_OVERFLOW;
                        n_aborted = 1'b1;
                    end else begin
                        w_has_res = 1'b1;
                        w_bvalid  = 1'b1;
                        w_byte    = {r_high, i_class.nibble};
                        n_count   = r_count + 1'b1;
                        n_pending = 1'b0;
                        n_high    = '0;
                    end
                end
                default: begin
                    w_has_res = 1'b1;
                    w_final   = 1'b1;
                    w_status  = ST_BAD_CHAR;
                    n_aborted = 1'b1;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_high    <= '0;
            r_count   <= '0;
            r_aborted <= 1'b0;
        end else if (w_proc) begin
            r_pending <= n_pending;
            r_high    <= n_high;
            r_count   <= n_count;
            r_aborted <= n_aborted;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_slot_free) begin
            r_out_valid <= w_proc && w_has_res;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_proc && w_has_res) begin
            r_out_byte   <= w_byte;
            r_out_bvalid <= w_bvalid;
            r_out_final  <= w_final;
            r_out_status <= w_status;
            r_out_count  <= n_aborted ? r_count : (w_final ? r_count : n_count);
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_data_byte  = r_out_byte;
    assign o_byte_valid = r_out_bvalid;
    assign o_final      = r_out_final;
    assign o_status     = r_out_status;

    // Reported count: low bits of the counter, zero-extended when narrower
    generate
        if (COUNT_WIDTH >= OCOUNT_W) begin : g_cnt_trunc
            assign o_byte_count = r_out_count[OCOUNT_W-1:0];
        end else begin : g_cnt_ext
            assign o_byte_count = OCOUNT_W'(r_out_count);
        end
    endgenerate

`ifndef SYNTHESIS
    // A byte beat never closes the string and always reports success
    a_byte_not_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_bvalid |-> !r_out_final && r_out_status == ST_OK)
        else $error("byte beat marked final or with error status");

    // A successful string end implies at least one byte was decoded
    a_ok_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_final && r_out_status == ST_OK |-> r_out_count != '0)
        else $error("ok end of string with zero bytes");

    // An error result leaves the string aborted
    a_error_aborts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && w_has_res && (w_status == ST_BAD_CHAR || w_status == ST_BAD_X ||
        w_status == ST_OVERFLOW) |=> r_aborted)
        else $error("error result did not abort the string");

    // Nothing is reported while aborted
    a_quiet_aborted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_aborted && w_proc |=> !r_out_valid)
        else $error("result produced while aborted");
`endif

endmodule

// ===== sv/hex_text_to_bytes_parser.sv =====
// Top level of the hex text to bytes parser: input beat register, capacity
// register, classifier and decoder core. Depends on hexp_pkg, hexp_classify, hexp_core.
//
// Takes one ASCII character per beat and turns hex digit pairs into bytes,
// skipping whitespace, ':', '-' and ','. A 0x/0X prefix is allowed while the
// pending nibble is zero. A NUL character ends the string with one final beat
// carrying status; an error gives one final beat and the rest of the string up
// to the NUL is dropped. Throughput is one character per clock while the output
// is not stalled: a character is held in the input register and its result lands
// in the output register. The only stall is back-pressure on the output register.
// byte_capacity is written through i_cfg_we/i_cfg_wdata; the user must write it only
// while the block is idle (the block does not enforce this). It resets to 256.
module hex_text_to_bytes_parser
    import hexp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    // input stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [7:0] text_char
    // output stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [23:0]       o_m_tdata,   // [7:0] data_byte, [23:8] byte_count
    output logic [7:0]        o_m_tuser,   // [0] byte_valid, [3:1] status, [7:4] zero
    output logic              o_m_tlast    // final_res
);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic [CAP_W-1:0]  r_capacity;
    logic              w_slot_free;
    t_char_class       w_class;
    logic [BYTE_W-1:0] w_byte;
    logic              w_bvalid;
    logic              w_final;
    logic [STATUS_W-1:0] w_status;
    logic [OCOUNT_W-1:0] w_count;

    assign o_s_tready = !r_in_valid || w_slot_free;

    // Input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
        end
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    hexp_classify u_classify (
        .i_char  (r_in_char),
        .o_class (w_class)
    );

    hexp_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid),
        .i_class      (w_class),
        .i_capacity   (r_capacity),
        .o_slot_free  (w_slot_free),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_data_byte  (w_byte),
        .o_byte_valid (w_bvalid),
        .o_final      (w_final),
        .o_status     (w_status),
        .o_byte_count (w_count)
    );

    // Output packing
    assign o_m_tdata = {w_count, w_byte};
    assign o_m_tuser = {4'b0000, w_status, w_bvalid};
    assign o_m_tlast = w_final;

endmodule

// ===== test/tb_hex_text_to_bytes_parser.sv =====
// Self-checking testbench for hex_text_to_bytes_parser: drives text characters,
// predicts every output beat and compares it field by field.
// Depends on hexp_pkg and the hex_text_to_bytes_parser RTL.
module tb_hex_text_to_bytes_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import hexp_pkg::*;

    // One predicted output beat
    typedef struct {
        logic [BYTE_W-1:0]   data;
        logic                valid;
        logic                fin;
        t_status             status;
        logic [OCOUNT_W-1:0] count;
    } t_result;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                cfg_we      = 1'b0;
    logic [CAP_W-1:0]    cfg_wdata   = '0;
    logic                s_tvalid    = 1'b0;
    logic                o_s_tready;
    logic [CHAR_W-1:0]   s_tdata     = '0;
    logic                o_m_tvalid;
    logic                m_tready    = 1'b0;
    logic [23:0]         o_m_tdata;  // [7:0] data_byte, [23:8] byte_count
    logic [7:0]          o_m_tuser;  // [0] byte_valid, [3:1] status, [7:4] zero
    logic                o_m_tlast;  // final_res

    // Characters waiting to be driven, and the beats the block still owes us
    logic [CHAR_W-1:0]   text_q[$];
    t_result             owed_beats[$];

    int                  src_idle_pct  = 0;
    int                  snk_stall_pct = 0;
    logic                sink_hold     = 1'b0;
    event                hold_go;

    int                  chars_queued  = 0;
    int                  chars_taken   = 0;
    int                  byte_beats    = 0;
    int                  end_beats     = 0;
    int                  errors        = 0;

    // Predictor state
    logic [CAP_W-1:0]           cap_now     = CAP_RESET;
    logic                       cur_pending = 1'b0;
    logic [3:0]                 cur_high    = '0;
    logic [COUNT_WIDTH_DEF-1:0] cur_count   = '0;
    logic                       cur_aborted = 1'b0;

    hex_text_to_bytes_parser #(
        .COUNT_WIDTH (COUNT_WIDTH_DEF)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Character class and nibble value
    function automatic t_kind char_kind(input logic [CHAR_W-1:0] c, output logic [3:0] v);
        v = '0;
        if (c == CH_NUL) return CK_TERM;
        if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE || c == CH_COLON ||
            c == CH_DASH || c == CH_COMMA) return CK_SKIP;
        if (c == CH_LX || c == CH_UX) return CK_X;
        if (c >= CH_0 && c <= CH_9) begin
            v = 4'(c - CH_0);
            return CK_DIGIT;
        end
        if (c >= CH_LA && c <= CH_LF) begin
            v = 4'(c - CH_LA) + NIB_TEN;
            return CK_DIGIT;
        end
        if (c >= CH_UA && c <= CH_UF) begin
            v = 4'(c - CH_UA) + NIB_TEN;
            return CK_DIGIT;
        end
        return CK_BAD;
    endfunction

    function automatic void clear_string_state();
        cur_pending = 1'b0;
        cur_high    = '0;
        cur_count   = '0;
        cur_aborted = 1'b0;
    endfunction

    // Advance the decoder by one character; returns 1 when a beat is due
    function automatic bit decode_char(input logic [CHAR_W-1:0] c, output t_result r);
        t_kind      k;
        logic [3:0] v;
        k        = char_kind(c, v);
        r.data   = '0;
        r.valid  = 1'b0;
        r.fin    = 1'b0;
        r.status = ST_OK;
        r.count  = cur_count[OCOUNT_W-1:0];
        if (cur_aborted) begin
            if (k == CK_TERM) clear_string_state();
            return 1'b0;
        end
        case (k)
            CK_TERM: begin
                r.fin    = 1'b1;
                r.status = cur_pending ? ST_ODD : ((cur_count == 0) ? ST_EMPTY : ST_OK);
                clear_string_state();
                return 1'b1;
            end
            CK_SKIP: return 1'b0;
            CK_X: begin
                // 0x prefix drops the zero nibble; anything else is an error
                if (cur_pending && cur_high == 0) begin
                    cur_pending = 1'b0;
                    return 1'b0;
                end
                r.fin       = 1'b1;
                r.status    = ST_BAD_X;
                cur_aborted = 1'b1;
                return 1'b1;
            end
            CK_BAD: begin
                r.fin       = 1'b1;
                r.status    = ST_BAD_CHAR;
                cur_aborted = 1'b1;
                return 1'b1;
            end
            default: begin
                if (!cur_pending) begin
                    cur_pending = 1'b1;
                    cur_high    = v;
                    return 1'b0;
                end
                if (cur_count >= cap_now || cur_count == '1) begin
                    r.fin       = 1'b1;
                    r.status    = ST_OVERFLOW;
                    cur_aborted = 1'b1;
                    return 1'b1;
                end
                cur_count   = cur_count + 1'b1;
                cur_pending = 1'b0;
                r.data      = {cur_high, v};
                r.valid     = 1'b1;
                r.count     = cur_count[OCOUNT_W-1:0];
                cur_high    = '0;
                return 1'b1;
            end
        endcase
    endfunction

    // Text driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || o_s_tready) begin
            if (text_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= text_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Input monitor: predict on every accepted character
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && s_tvalid && o_s_tready) begin
            if (decode_char(s_tdata, r)) owed_beats.push_back(r);
            chars_taken++;
        end
    end

    // Output back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps going
    initial begin
        forever begin
            @(hold_go);
            @(posedge i_clk);
            sink_hold <= 1'b1;
            repeat (300) @(posedge i_clk);
            sink_hold <= 1'b0;
        end
    end

    // Output monitor: compare against the oldest owed beat
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (owed_beats.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: data %h valid %b last %b status %0d count %0d",
                             o_m_tdata[7:0], o_m_tuser[0], o_m_tlast, o_m_tuser[3:1],
                             o_m_tdata[23:8]);
            end else begin
                r = owed_beats.pop_front();
                if (r.valid) byte_beats++;
                if (r.fin) end_beats++;
                if (o_m_tdata[7:0] !== r.data || o_m_tuser[0] !== r.valid ||
                    o_m_tlast !== r.fin || o_m_tuser[3:1] !== r.status ||
                    o_m_tdata[23:8] !== r.count) begin
                    errors++;
                    if (errors <= 10) begin
                        $write("mismatch: exp data %h valid %b last %b status %0d count %0d",
                               r.data, r.valid, r.fin, r.status, r.count);
                        $display(" | got data %h valid %b last %b status %0d count %0d",
                                 o_m_tdata[7:0], o_m_tuser[0], o_m_tlast, o_m_tuser[3:1],
                                 o_m_tdata[23:8]);
                    end
                end
            end
        end
    end

    task automatic push_char(input logic [CHAR_W-1:0] c);
        text_q.push_back(c);
        chars_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n, input bit up);
        if (n < NIB_TEN) return CH_0 + n;
        return (up ? CH_UA : CH_LA) + (n - NIB_TEN);
    endfunction

    function automatic logic [CHAR_W-1:0] skip_char();
        int k;
        k = $urandom_range(8);
        if (k < 5) return CH_TAB + CHAR_W'(k);
        case (k)
            5:       return CH_SPACE;
            6:       return CH_COLON;
            7:       return CH_DASH;
            default: return CH_COMMA;
        endcase
    endfunction

    // A character outside every accepted class
    function automatic logic [CHAR_W-1:0] bad_char();
        logic [CHAR_W-1:0] c;
        logic [3:0]        v;
        do c = CHAR_W'($urandom_range(255)); while (char_kind(c, v) != CK_BAD);
        return c;
    endfunction

    task automatic push_fault(input int kind);
        case (kind)
            0:       push_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            1:       push_char(bad_char());
            default: push_char($urandom_range(1) ? CH_LX : CH_UX);
        endcase
    endtask

    // One string: mostly well formed, some with a fault, some pure noise
    task automatic queue_random_string();
        int pick;
        int nbytes;
        int fault_at;
        int fault_kind;
        pick = $urandom_range(99);
        if (pick < 15) begin
            repeat ($urandom_range(1, 16)) push_char(CHAR_W'($urandom_range(255)));
        end else begin
            nbytes     = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
            fault_at   = (pick < 35) ? $urandom_range(nbytes) : -1;
            fault_kind = $urandom_range(2);
            if ($urandom_range(3) == 0) begin
                push_char(CH_0);
                push_char($urandom_range(1) ? CH_LX : CH_UX);
            end
            for (int i = 0; i < nbytes; i++) begin
                if (i == fault_at) push_fault(fault_kind);
                if ($urandom_range(2) == 0) push_char(skip_char());
                if ($urandom_range(9) == 0) begin
                    push_char(CH_0);
                    push_char($urandom_range(1) ? CH_LX : CH_UX);
                end
                push_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
                push_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            end
            if (fault_at == nbytes) push_fault(fault_kind);
        end
        push_char(CH_NUL);
    endtask

    // Wait for everything sent to be taken and every owed beat to arrive
    task automatic settle();
        int guard;
        guard = 0;
        while ((chars_taken != chars_queued || owed_beats.size() != 0) && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cap(input logic [CAP_W-1:0] v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        cap_now    = v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int src_pct,
                             input int snk_pct, input int n_chars, input bit hold);
        int start;
        write_cap(cap);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        start         = chars_queued;
        while (chars_queued - start < n_chars) queue_random_string();
        if (hold) -> hold_go;
        settle();
    endtask

    // Stimulus
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings at the reset capacity
        push_text("0xAf:09");
        push_char(CH_TAB);
        push_text("Fa");
        push_char(CH_NUL);
        push_char(CH_NUL);
        push_text("1Xg");
        push_char(CH_NUL);
        push_text("5");
        push_char(CH_NUL);
        push_text("z");
        push_char(CH_NUL);
        push_text(" ,-");
        push_char(CH_CR);
        push_char(CH_NUL);
        settle();

        // Random phases: capacity extremes and the idling mixes
        run_phase(16'd0,     0,  0,  100, 1'b0);
        run_phase(16'hFFFF,  0,  0,  300, 1'b1);
        run_phase(16'd3,     78, 0,  300, 1'b0);
        run_phase(CAP_W'($urandom_range(2, 16)), 0, 78, 300, 1'b0);
        run_phase(16'd1,     26, 26, 200, 1'b0);

        if (owed_beats.size() != 0 || chars_taken != chars_queued) errors++;
        $display("Run covered %0d characters over capacities 256, 0, 65535, 3, 1 and a random one,",
                 chars_taken);
        $display("with %0d byte beats and %0d end-of-string beats compared.",
                 byte_beats, end_beats);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
